[hdl/plru_pkg.sv]
// Shared types, sizes and helpers for the protected LRU replacement block.
// Used by protected_lru_replacement_top and plru_rank under hdl; depends on nothing else.
`default_nettype none

package plru_pkg;

  // cache geometry and counter width
  localparam int WAYS       = 8;
  localparam int SETS       = 64;
  localparam int COUNT_BITS = 16;

  // fixed widths of the interface fields
  localparam int OP_FIELD_BITS  = 1;
  localparam int SET_FIELD_BITS = 6;
  localparam int WAY_FIELD_BITS = 3;
  localparam int MAX_CNT_BITS   = 16;
  localparam int PROT_BITS      = 4;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  // derived internal widths
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int POS_BITS = $clog2(WAYS + 1);

  typedef logic [COUNT_BITS-1:0]   cnt_t;
  typedef logic [WAY_BITS-1:0]     way_t;
  typedef logic [SET_BITS-1:0]     set_t;
  typedef logic [POS_BITS-1:0]     pos_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_MAX_COUNT    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_PROTECT_WAYS = cfg_idx_t'(1);

  // access kinds
  localparam logic OP_HIT  = 1'b0;
  localparam logic OP_MISS = 1'b1;

  // one stored row holds a whole set
  typedef struct packed {
    cnt_t [WAYS-1:0] cnt;
    way_t [WAYS-1:0] rnk;
  } row_t;

  localparam int ROW_BITS = $bits(row_t);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_HIT,
    ST_WALK,
    ST_WRITE
  } state_t;

  // contents of a set that was never written
  function automatic row_t reset_row();
    row_t r;
    for (int k = 0; k < WAYS; k++) begin
      r.cnt[k] = '0;
      r.rnk[k] = way_t'(k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/protected_lru_replacement_top.sv]
// A hit passes the read, load, hit and write states before the next beat can be taken;
// a miss passes read, load, a walk over every way and write, which registers the victim
// and waits out a stalled output. The priority unit ranks one way per cycle of the walk.
// An item with an out-of-range set or hit way is dropped in the cycle it is accepted.
// Reset (synchronous): sets read as zero counts and rank equal to way, max_count 255,
// protect_ways 1; per-set valid flags clear at once, so no clearing pass is needed.
`default_nettype none

module protected_lru_replacement_top
  import plru_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  // access channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [OP_FIELD_BITS-1:0]  operation,
  input  wire logic [SET_FIELD_BITS-1:0] set_index,
  input  wire logic [WAY_FIELD_BITS-1:0] hit_way,
  // victim channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [WAY_FIELD_BITS-1:0]      victim_way,
  // configuration channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // contents of a set that was never written
  localparam row_t FRESH_ROW = reset_row();

  state_t state, state_next;

  // configuration registers
  logic [MAX_CNT_BITS-1:0] max_count;
  logic [PROT_BITS-1:0]    protect_ways;

  // latched item
  logic op_reg;
  set_t set_reg;
  way_t hw_reg;

  // working copy of the set
  cnt_t [WAYS-1:0] cnt;
  way_t [WAYS-1:0] rnk;
  logic [SETS-1:0] row_valid;

  // walk bookkeeping
  way_t walk;
  logic have_vic;
  way_t vic;
  way_t vic_rank;
  way_t mru;

  // control strobes
  logic accept;
  logic item_ok;
  logic ram_rd_en;
  logic ram_wr_en;
  logic walk_last;
  logic out_free;

  row_t rd_row;
  row_t wr_row;
  pos_t pos;
  pos_t n_eff;
  logic prot;
  way_t target;
  cnt_t inc;
  logic halve;
  cnt_t [WAYS-1:0] hit_cnt;
  logic [WAYS-1:0] rank_seen;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign item_ok   = (int'(set_index) < SETS) &&
                     ((operation == OP_MISS) || (int'(hit_way) < WAYS));
  assign walk_last = (walk == way_t'(WAYS - 1));
  assign out_free  = !out_valid || !out_stall;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_count    <= MAX_CNT_BITS'(255);
      protect_ways <= PROT_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_COUNT:    max_count    <= cfg_data[MAX_CNT_BITS-1:0];
        CFG_PROTECT_WAYS: protect_ways <= cfg_data[PROT_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // clamp the protected count to the number of ways
  assign n_eff = (int'(protect_ways) > WAYS) ? pos_t'(WAYS) : pos_t'(protect_ways);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && item_ok) state_next = ST_READ;
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = (op_reg == OP_MISS) ? ST_WALK : ST_HIT;
      ST_HIT:   state_next = ST_WRITE;
      ST_WALK:  if (walk_last) state_next = ST_WRITE;
      ST_WRITE: if ((op_reg == OP_HIT) || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    case (state)
      ST_IDLE:  in_stall  = 1'b0;
      ST_READ:  ram_rd_en = 1'b1;
      ST_WRITE: ram_wr_en = (op_reg == OP_HIT) || out_free;
      default:  ;
    endcase
  end

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg  <= operation[0];
      set_reg <= set_t'(set_index);
      hw_reg  <= way_t'(hit_way);
    end
  end

  plru_ram #(
    .DEPTH (SETS),
    .WIDTH (ROW_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (set_reg),
    .wr_data (wr_row),
    .rd_en   (ram_rd_en),
    .rd_addr (set_reg),
    .rd_data (rd_row)
  );

  // mark sets that hold real data
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_wr_en) begin
      row_valid[set_reg] <= 1'b1;
    end
  end

  // saturating increment and halving for a hit
  always_comb begin
    inc   = (cnt[hw_reg] == '1) ? cnt[hw_reg] : cnt[hw_reg] + cnt_t'(1);
    halve = (32'(inc) >= 32'(max_count));
    for (int k = 0; k < WAYS; k++) begin
      hit_cnt[k] = (way_t'(k) == hw_reg) ? inc : cnt[k];
      if (halve) begin
        hit_cnt[k] = hit_cnt[k] >> 1;
      end
    end
  end

  plru_rank u_rank (
    .cnt  (cnt),
    .rnk  (rnk),
    .cand (walk),
    .pos  (pos)
  );

  assign prot = (pos < n_eff);

  // working set: load, hit update, walk
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (row_valid[set_reg]) begin
          cnt <= rd_row.cnt;
          rnk <= rd_row.rnk;
        end else begin
          cnt <= FRESH_ROW.cnt;
          rnk <= FRESH_ROW.rnk;
        end
        walk     <= '0;
        have_vic <= 1'b0;
        mru      <= '0;
      end
      ST_HIT: begin
        cnt <= hit_cnt;
      end
      ST_WALK: begin
        if (!prot && (!have_vic || (rnk[walk] > vic_rank))) begin
          vic      <= walk;
          vic_rank <= rnk[walk];
          have_vic <= 1'b1;
        end
        if (rnk[walk] == '0) begin
          mru <= walk;
        end
        walk <= walk + way_t'(1);
      end
      default: ;
    endcase
  end

  // move the target way to most recent, clear a victim's counter
  always_comb begin
    target = (op_reg == OP_MISS) ? (have_vic ? vic : mru) : hw_reg;
    for (int k = 0; k < WAYS; k++) begin
      if (way_t'(k) == target) begin
        wr_row.rnk[k] = '0;
        wr_row.cnt[k] = (op_reg == OP_MISS) ? '0 : cnt[k];
      end else begin
        wr_row.rnk[k] = (rnk[k] < rnk[target]) ? rnk[k] + way_t'(1) : rnk[k];
        wr_row.cnt[k] = cnt[k];
      end
    end
  end

  // result register: load a new victim, else drop a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ram_wr_en && (op_reg == OP_MISS)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_wr_en && (op_reg == OP_MISS)) begin
      victim_way <= WAY_FIELD_BITS'(target);
    end
  end

  // ranks seen in the working set, for checking
  always_comb begin
    rank_seen = '0;
    for (int k = 0; k < WAYS; k++) begin
      rank_seen[rnk[k]] = 1'b1;
    end
  end

  // a new victim appears only after a miss write
  a_out_from_miss: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_WRITE) && ($past(op_reg) == OP_MISS))
    else $error("victim raised without a miss write");

  // with fewer protected than ways, the walk must find an unprotected way
  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && op_reg == OP_MISS && int'(n_eff) < WAYS) |-> have_vic)
    else $error("miss walk found no unprotected way");

  // the working ranks stay a permutation of the ways
  a_rank_perm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK || state == ST_HIT) |-> (&rank_seen))
    else $error("recency ranks are not a permutation");

  // a stored row is marked valid after its write
  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |=> row_valid[$past(set_reg)])
    else $error("written set not marked valid");

  // the block takes no beat while a set is in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> in_stall ##1 in_stall)
    else $error("input taken while set in flight");

endmodule

`default_nettype wire

[hdl/plru_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds one row per cache set for the replacement block.
`default_nettype none

module plru_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/plru_rank.sv]
// Priority position unit: counts the ways that outrank one candidate way.
// Depends on plru_pkg; shared by every step of the miss walk.
`default_nettype none

module plru_rank
  import plru_pkg::*;
(
  input  wire cnt_t [WAYS-1:0] cnt,
  input  wire way_t [WAYS-1:0] rnk,
  input  wire way_t            cand,
  output pos_t                 pos
);

  logic [WAYS-1:0] better;

  // a way outranks the candidate on a larger count, or an equal count and more recent use
  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      better[k] = (cnt[k] > cnt[cand]) ||
                  ((cnt[k] == cnt[cand]) && (rnk[k] < rnk[cand]));
    end
  end

  // population count of the outranking ways
  always_comb begin
    pos = '0;
    for (int k = 0; k < WAYS; k++) begin
      pos = pos + pos_t'(better[k]);
    end
  end

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for protected_lru_replacement_top: a directed table, then random
// accesses under several register settings, each victim checked against a local predictor
// or a typed-in value. Depends on plru_pkg and the RTL under hdl only.
module tb;
  import plru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 24;    // covers the slowest access (miss) with margin
  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off to back up the block
  localparam int ITEMS_PER_PHASE = 270;
  localparam int NUM_PHASES      = 7;
  localparam int RANDOM_PHASE    = 5;
  localparam int CALM_PHASE      = 2;
  localparam int SQUEEZE_PHASE   = 3;
  localparam int IDLE_PCT        = 15;
  localparam int MISS_PCT        = 35;

  // indexes that decode to no register
  localparam cfg_idx_t CFG_SPARE_LO = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_SPARE_HI = cfg_idx_t'(3);

  typedef struct packed {
    logic op;
    set_t set_sel;
    way_t way_sel;
    logic known;       // victim typed in below rather than predicted
    way_t victim;
  } access_row_t;

  // directed accesses under the reset settings (max_count 255, protect_ways 1)
  localparam int NUM_ROWS = 16;
  localparam access_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_MISS, 6'd0,  3'd0, 1'b1, 3'd7},  // fresh set: way 0 shielded, way 7 oldest
    '{OP_MISS, 6'd63, 3'd7, 1'b1, 3'd7},  // top set, hit way ignored
    '{OP_MISS, 6'd0,  3'd5, 1'b0, 3'd0},
    '{OP_HIT,  6'd5,  3'd3, 1'b0, 3'd0},
    '{OP_HIT,  6'd5,  3'd3, 1'b0, 3'd0},
    '{OP_HIT,  6'd5,  3'd0, 1'b0, 3'd0},
    '{OP_MISS, 6'd5,  3'd0, 1'b0, 3'd0},
    '{OP_HIT,  6'd63, 3'd7, 1'b0, 3'd0},
    '{OP_HIT,  6'd63, 3'd0, 1'b0, 3'd0},
    '{OP_MISS, 6'd63, 3'd3, 1'b0, 3'd0},
    '{OP_HIT,  6'd0,  3'd7, 1'b0, 3'd0},
    '{OP_MISS, 6'd0,  3'd1, 1'b0, 3'd0},
    '{OP_MISS, 6'd5,  3'd7, 1'b0, 3'd0},
    '{OP_HIT,  6'd42, 3'd5, 1'b0, 3'd0},
    '{OP_MISS, 6'd21, 3'd2, 1'b0, 3'd0},
    '{OP_MISS, 6'd42, 3'd0, 1'b0, 3'd0}
  };

  // settings per random phase; the random phase draws its own
  localparam cnt_t PHASE_MAX [NUM_PHASES] = '{16'd0, 16'd65535, 16'd3, 16'd7, 16'd16,
                                              16'd255, 16'd255};
  localparam logic [PROT_BITS-1:0] PHASE_PROT [NUM_PHASES] = '{4'd0, 4'd8, 4'd15, 4'd2,
                                                               4'd4, 4'd1, 4'd1};

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [OP_FIELD_BITS-1:0]  operation = '0;
  logic [SET_FIELD_BITS-1:0] set_index = '0;
  logic [WAY_FIELD_BITS-1:0] hit_way   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [WAY_FIELD_BITS-1:0] victim_way;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // predictor state
  cnt_t                 count_mem [SETS][WAYS];
  way_t                 rank_mem  [SETS][WAYS];
  cnt_t                 max_cfg;
  logic [PROT_BITS-1:0] prot_cfg;

  way_t pending_victims [$];
  int   fails       = 0;
  bit   calm_phase  = 1'b0;
  bit   squeeze_req = 1'b0;

  protected_lru_replacement_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .set_index  (set_index),
    .hit_way    (hit_way),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .victim_way (victim_way),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // move a way to rank 0, aging every way that was more recent
  function automatic void promote_way(int s, int w);
    way_t old;
    old = rank_mem[s][w];
    for (int k = 0; k < WAYS; k++) begin
      if (rank_mem[s][k] < old) rank_mem[s][k] = rank_mem[s][k] + 1'b1;
    end
    rank_mem[s][w] = '0;
  endfunction

  // update the predicted set state; return 1 with the victim on a miss
  function automatic bit apply_access(logic op, set_t s, way_t w, output way_t victim);
    int n;
    int best;
    int pick;
    int mru;
    bit have;
    bit found;
    bit [WAYS-1:0] shielded;
    victim = '0;
    if (op == OP_HIT) begin
      if (count_mem[s][w] != '1) count_mem[s][w] = count_mem[s][w] + 1'b1;
      if (count_mem[s][w] >= max_cfg) begin
        for (int k = 0; k < WAYS; k++) count_mem[s][k] = count_mem[s][k] >> 1;
      end
      promote_way(s, w);
      return 1'b0;
    end
    // shield the busiest ways, ties to the more recent one
    n = (prot_cfg > WAYS) ? WAYS : int'(prot_cfg);
    shielded = '0;
    for (int k = 0; k < n; k++) begin
      have = 1'b0;
      best = 0;
      for (int j = 0; j < WAYS; j++) begin
        if (!shielded[j] && (!have || count_mem[s][j] > count_mem[s][best] ||
            (count_mem[s][j] == count_mem[s][best] && rank_mem[s][j] < rank_mem[s][best])))
        begin
          best = j;
          have = 1'b1;
        end
      end
      if (have) shielded[best] = 1'b1;
    end
    // evict the oldest unshielded way, or the newest when all are shielded
    found = 1'b0;
    pick = 0;
    mru = 0;
    for (int j = 0; j < WAYS; j++) begin
      if (rank_mem[s][j] == '0) mru = j;
      if (!shielded[j] && (!found || rank_mem[s][j] > rank_mem[s][pick])) begin
        pick = j;
        found = 1'b1;
      end
    end
    if (!found) pick = mru;
    count_mem[s][pick] = '0;
    promote_way(s, pick);
    victim = way_t'(pick);
    return 1'b1;
  endfunction

  // offer one access beat, predict on acceptance, then maybe idle
  task automatic send_access(logic op, set_t s, way_t w, logic known, way_t known_victim);
    way_t predicted;
    bit   has_victim;
    in_valid  <= 1'b1;
    operation <= op;
    set_index <= s;
    hit_way   <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_victim = apply_access(op, s, w, predicted);
    if (has_victim) pending_victims.push_back(known ? known_victim : predicted);
    if (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold a register beat until taken; the caller drops cfg_valid after the last one
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_COUNT:    max_cfg = value;
      CFG_PROTECT_WAYS: prot_cfg = value[PROT_BITS-1:0];
      default: ;
    endcase
  endtask

  // wait for every victim, then let trailing hits finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random accesses, mostly aimed at a pool of four sets and often at one busy way
  task automatic run_random(int items);
    set_t pool [4];
    way_t busy_way;
    logic op;
    set_t s;
    way_t w;
    for (int k = 0; k < 4; k++) pool[k] = set_t'($urandom_range(SETS - 1));
    busy_way = way_t'($urandom_range(WAYS - 1));
    repeat (items) begin
      op = ($urandom_range(99) < MISS_PCT) ? OP_MISS : OP_HIT;
      s  = ($urandom_range(99) < 75) ? pool[$urandom_range(3)]
                                     : set_t'($urandom_range(SETS - 1));
      w  = ($urandom_range(99) < 40) ? busy_way : way_t'($urandom_range(WAYS - 1));
      send_access(op, s, w, 1'b0, '0);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= (!calm_phase && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // check each victim beat against the oldest prediction
  always @(posedge clk) begin : victim_check
    way_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_victims.size() == 0) begin
        $error("victim_way: none expected, actual %0d", victim_way);
        fails++;
      end else begin
        want = pending_victims.pop_front();
        if (victim_way !== want) begin
          $error("victim_way: expected %0d, actual %0d", want, victim_way);
          fails++;
        end
      end
    end
  end

  initial begin
    cnt_t                 maxv;
    logic [PROT_BITS-1:0] protv;
    logic [CFG_DATA_BITS-1:0] noise;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        count_mem[s][w] = '0;
        rank_mem[s][w]  = way_t'(w);
      end
    end
    max_cfg  = 16'd255;
    prot_cfg = 4'd1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // unused indexes must leave the settings alone
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_access(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].set_sel, DIRECTED_ROWS[r].way_sel,
                  DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].victim);
    end
    settle_block();

    for (int p = 0; p < NUM_PHASES; p++) begin
      maxv  = PHASE_MAX[p];
      protv = PHASE_PROT[p];
      if (p == RANDOM_PHASE) begin
        maxv  = cnt_t'($urandom_range(2, 40));
        protv = PROT_BITS'($urandom_range(15));
      end
      // junk above the protect field must be masked off
      noise = 16'($urandom) & ~16'((1 << PROT_BITS) - 1);
      write_reg(CFG_MAX_COUNT, maxv);
      write_reg(CFG_PROTECT_WAYS, noise | 16'(protv));
      cfg_valid  <= 1'b0;
      calm_phase  = (p == CALM_PHASE);
      if (p == SQUEEZE_PHASE) squeeze_req = 1'b1;
      run_random(ITEMS_PER_PHASE);
      settle_block();
    end

    if (fails == 0) begin
      $display("protected_lru_replacement_top verification clean");
    end else begin
      $display("protected_lru_replacement_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("protected_lru_replacement_top verification failed");
    $finish;
  end

endmodule

[sim.f]
hdl/plru_pkg.sv
hdl/plru_ram.sv
hdl/plru_rank.sv
hdl/protected_lru_replacement_top.sv
bench/tb.sv
